// ----- rtl/tmsq_pkg.sv -----
// Shared constants and types of the tone melody sequencer.
`default_nettype none

package tmsq_pkg;

	localparam int TBL_DEPTH = 32;
	localparam int TBL_AW    = $clog2(TBL_DEPTH);

	localparam int FREQ_W = 12;
	localparam int DUR_W  = 16;
	localparam int IDX_W  = 5;
	localparam int RATE_W = 11;
	localparam int POS_W  = 5;

	// 131072 / freq needs 18 quotient bits (freq of one gives 2^17)
	localparam int QUO_W = 18;
	localparam int REM_W = FREQ_W;

	localparam logic [QUO_W-1:0] RATE_NUMER = 18'h20000;
	localparam logic [RATE_W:0]  RATE_BASE  = 12'd2048;

	localparam logic FUNC_TICK = 1'b0;
	localparam logic FUNC_LOAD = 1'b1;

	typedef struct packed {
		logic [FREQ_W-1:0] freq;
		logic [DUR_W-1:0]  dur;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic busy;
		logic done;
	} div_status_t;

endpackage

`default_nettype wire

// ----- rtl/tmsq_cmd_if.sv -----
// Input channel of the sequencer: tick and table-load words.
`default_nettype none

interface tmsq_cmd_if import tmsq_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              func;
	logic [IDX_W-1:0]  load_index;
	logic [FREQ_W-1:0] load_frequency;
	logic [DUR_W-1:0]  load_duration;

	modport source (output valid, func, load_index, load_frequency, load_duration,
		input ready);
	modport sink (input valid, func, load_index, load_frequency, load_duration,
		output ready);
endinterface

`default_nettype wire

// ----- rtl/tmsq_note_if.sv -----
// Output channel of the sequencer: one word per note start.
`default_nettype none

interface tmsq_note_if import tmsq_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [RATE_W-1:0] tone_rate;
	logic              tone_on;
	logic [POS_W-1:0]  note_position;

	modport source (output valid, tone_rate, tone_on, note_position, input ready);
	modport sink (input valid, tone_rate, tone_on, note_position, output ready);
endinterface

`default_nettype wire

// ----- rtl/tmsq_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module tmsq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ----- rtl/tmsq_div.sv -----
// Bit-serial restoring divider: 131072 / divisor, one quotient bit per cycle.
`default_nettype none

module tmsq_div import tmsq_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [FREQ_W-1:0] divisor,
	output div_status_t            status,
	output logic      [QUO_W-1:0]  quotient
);

	localparam int CNT_W = $clog2(QUO_W);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [REM_W-1:0]  rem_q;
	logic [QUO_W-1:0]  dvd_q;
	logic [QUO_W-1:0]  quo_q;
	logic [FREQ_W-1:0] dsr_q;

	logic [REM_W:0]    trial;
	logic              fits;

	assign trial = {rem_q, dvd_q[QUO_W-1]};
	assign fits  = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			rem_q  <= '0;
			dvd_q  <= '0;
			quo_q  <= '0;
			dsr_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				rem_q  <= '0;
				dvd_q  <= RATE_NUMER;
				quo_q  <= '0;
				dsr_q  <= divisor;
			end else if (busy_q) begin
				// remainder stays below the divisor, so it fits in REM_W bits
				rem_q <= fits ? REM_W'(trial - {1'b0, dsr_q}) : trial[REM_W-1:0];
				quo_q <= {quo_q[QUO_W-2:0], fits};
				dvd_q <= {dvd_q[QUO_W-2:0], 1'b0};
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(QUO_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign status.busy = busy_q;
	assign status.done = done_q;
	assign quotient    = quo_q;

endmodule

`default_nettype wire

// ----- rtl/tone_melody_sequencer_top.sv -----
// Tone melody sequencer: note table, countdown and rate word generation.
//
// Load words (func = 1) write one note table entry; an index at or beyond the table depth is
// dropped. A tick (func = 0) with a running countdown only decrements it. A tick that finds
// the countdown at zero starts the current note: the entry is read, the countdown reloads
// with its duration, the position advances (wrapping to 0 past the last entry or at a
// zero-frequency entry) and one word goes out with the rate 2048 - 131072/frequency,
// saturated at zero, tone_on set, or with rate and tone_on both zero for a zero frequency;
// note_position always carries the index of the note started. Such a tick holds the command
// side through table read, next-entry read, then the 18-step bit-serial divider, after which
// the word is registered. A zero-frequency note skips the divider. Either waits longer while
// an earlier word is still unread. The output register lets the next command in while a word
// waits. The table reads as all zero after reset through per-entry valid bits; no clearing
// pass.
`default_nettype none

module tone_melody_sequencer_top import tmsq_pkg::*; (
	input wire logic  clk,
	input wire logic  arst_n,
	tmsq_cmd_if.sink  cmd,
	tmsq_note_if.source note
);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_CUR  = 4'b0010,
		S_NEXT = 4'b0100,
		S_DIV  = 4'b1000
	} state_t;

	state_t              state_q;
	logic [TBL_AW-1:0]   pos_q;
	logic [TBL_AW-1:0]   emit_pos_q;
	logic [DUR_W-1:0]    ticks_q;
	logic [FREQ_W-1:0]   cur_freq_q;
	logic                last_q;
	logic [TBL_DEPTH-1:0] valid_q;
	logic                rd_valid_q;
	logic                out_valid_q;
	logic [RATE_W-1:0]   out_rate_q;
	logic                out_on_q;
	logic [POS_W-1:0]    out_pos_q;

	logic                cmd_acc;
	logic                ram_we;
	logic [TBL_AW-1:0]   waddr;
	logic [TBL_AW-1:0]   raddr;
	entry_t              wr_entry;
	entry_t              ram_rdata;
	entry_t              rd_entry;
	logic                div_start;
	div_status_t         div_st;
	logic [QUO_W-1:0]    quotient;
	logic [RATE_W-1:0]   rate_word;
	logic                slot_free;
	logic                word_emit;

	assign cmd.ready = (state_q == S_IDLE);
	assign cmd_acc   = cmd.valid && cmd.ready;

	assign waddr          = TBL_AW'(cmd.load_index);
	assign wr_entry.freq  = cmd.load_frequency;
	assign wr_entry.dur   = cmd.load_duration;
	assign ram_we = cmd_acc && (cmd.func == FUNC_LOAD) && (32'(cmd.load_index) < TBL_DEPTH);

	// current entry while idle, the following one while the note starts
	assign raddr = (state_q == S_CUR) ? TBL_AW'(pos_q + 1'b1) : pos_q;

	tmsq_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(TBL_DEPTH)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(waddr),
		.wdata(wr_entry),
		.raddr(raddr),
		.rdata(ram_rdata)
	);

	assign rd_entry = rd_valid_q ? ram_rdata : '0;

	assign div_start = (state_q == S_CUR) && (rd_entry.freq != '0);

	tmsq_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.divisor (rd_entry.freq),
		.status  (div_st),
		.quotient(quotient)
	);

	always_comb begin
		if (cur_freq_q == '0 || quotient >= QUO_W'(RATE_BASE)) begin
			rate_word = '0;
		end else begin
			rate_word = RATE_W'(RATE_BASE - quotient[RATE_W:0]);
		end
	end

	assign slot_free = !out_valid_q || note.ready;
	assign word_emit = (state_q == S_DIV) && !div_st.busy && slot_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pos_q       <= '0;
			emit_pos_q  <= '0;
			ticks_q     <= '0;
			cur_freq_q  <= '0;
			last_q      <= 1'b0;
			valid_q     <= '0;
			rd_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
			out_rate_q  <= '0;
			out_on_q    <= 1'b0;
			out_pos_q   <= '0;
		end else begin
			rd_valid_q <= valid_q[raddr];
			if (ram_we) begin
				valid_q[waddr] <= 1'b1;
			end
			// a new word may replace the one taken at this very edge
			if (word_emit) begin
				out_valid_q <= 1'b1;
			end else if (note.valid && note.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (cmd_acc && cmd.func == FUNC_TICK) begin
						if (ticks_q != '0) begin
							ticks_q <= ticks_q - 1'b1;
						end else begin
							state_q <= S_CUR;
						end
					end
				end
				S_CUR: begin
					cur_freq_q <= rd_entry.freq;
					ticks_q    <= rd_entry.dur;
					emit_pos_q <= pos_q;
					last_q     <= (pos_q == TBL_AW'(TBL_DEPTH - 1));
					state_q    <= S_NEXT;
				end
				S_NEXT: begin
					if (last_q || rd_entry.freq == '0) begin
						pos_q <= '0;
					end else begin
						pos_q <= TBL_AW'(pos_q + 1'b1);
					end
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (word_emit) begin
						out_rate_q  <= rate_word;
						out_on_q    <= (cur_freq_q != '0);
						out_pos_q   <= POS_W'(emit_pos_q);
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign note.valid         = out_valid_q;
	assign note.tone_rate     = out_rate_q;
	assign note.tone_on       = out_on_q;
	assign note.note_position = out_pos_q;

	// a silent note never carries a rate
	a_silent_zero_rate: assert property (@(posedge clk) disable iff (!arst_n)
		(note.valid && !note.tone_on) |-> (note.tone_rate == '0))
		else $error("silent note with nonzero rate");

	// divider finishes only while the sequencer waits for it
	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_st.done |-> (state_q == S_DIV))
		else $error("divider finished outside wait state");

	// a counting tick takes exactly one off the countdown
	a_tick_decrement: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_acc && cmd.func == FUNC_TICK && ticks_q != '0)
		|=> (ticks_q == $past(ticks_q) - 1'b1) && (state_q == S_IDLE))
		else $error("countdown tick misbehaved");

	// a new word is never written over one that has not been taken
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(note.valid && !note.ready) |=> note.valid)
		else $error("pending output word dropped");

	// position never leaves the table
	a_pos_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(pos_q) < TBL_DEPTH)
		else $error("note position beyond table");

endmodule

`default_nettype wire

// ----- tb/sv/tone_melody_sequencer_check.sv -----
// Note-word checker: mirrors the note table and countdown, compares every note word.
`timescale 1ns / 100ps

module tone_melody_sequencer_check import tmsq_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	tmsq_cmd_if       cmd,
	tmsq_note_if      note,
	output int        fails,
	output int        pending,
	output int        notes_checked,
	output int        silent_notes,
	output int        clipped_notes
);

	localparam int PRINT_CAP = 40;

	typedef struct packed {
		logic [RATE_W-1:0] rate;
		logic              on;
		logic [POS_W-1:0]  pos;
	} note_word_t;

	logic [FREQ_W-1:0] tune_freq [TBL_DEPTH];
	logic [DUR_W-1:0]  tune_dur  [TBL_DEPTH];
	logic [POS_W-1:0]  play_pos;
	logic [DUR_W-1:0]  countdown;
	note_word_t        notes_due [$];
	note_word_t        seen;
	note_word_t        want;
	note_word_t        due;

	function automatic logic [RATE_W-1:0] tone_rate_of(input logic [FREQ_W-1:0] freq);
		int quo;
		quo = int'(RATE_NUMER) / int'(freq);
		if (quo >= int'(RATE_BASE))
			return '0;
		return RATE_W'(int'(RATE_BASE) - quo);
	endfunction

	// Note start: read the entry, reload the countdown, move the play position on.
	function automatic note_word_t start_note();
		note_word_t w;
		int nxt;
		w.pos  = play_pos;
		w.on   = (tune_freq[play_pos] != '0);
		w.rate = w.on ? tone_rate_of(tune_freq[play_pos]) : '0;
		countdown = tune_dur[play_pos];
		nxt = int'(play_pos) + 1;
		// wrap past the last entry or at an end-of-melody entry
		if (nxt >= TBL_DEPTH || tune_freq[nxt] == '0)
			nxt = 0;
		play_pos = POS_W'(nxt);
		return w;
	endfunction

	task automatic report_mismatch(input string msg);
		if (fails < PRINT_CAP)
			$display("%0t ns note mismatch: %s", $time, msg);
		fails++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (tune_freq[i]) begin
				tune_freq[i] = '0;
				tune_dur[i]  = '0;
			end
			play_pos = '0;
			countdown = '0;
			notes_due.delete();
			fails = 0;
			notes_checked = 0;
			silent_notes = 0;
			clipped_notes = 0;
			pending <= 0;
		end else begin
			if (note.valid && note.ready) begin
				seen.rate = note.tone_rate;
				seen.on   = note.tone_on;
				seen.pos  = note.note_position;
				if (notes_due.size() == 0) begin
					report_mismatch($sformatf("word with nothing expected, position %0d", seen.pos));
				end else begin
					want = notes_due.pop_front();
					notes_checked++;
					if (seen.rate != want.rate)
						report_mismatch($sformatf("tone_rate at position %0d: got %0d, wanted %0d",
							want.pos, seen.rate, want.rate));
					if (seen.on != want.on)
						report_mismatch($sformatf("tone_on at position %0d: got %0d, wanted %0d",
							want.pos, seen.on, want.on));
					if (seen.pos != want.pos)
						report_mismatch($sformatf("note_position: got %0d, wanted %0d",
							seen.pos, want.pos));
				end
			end
			if (cmd.valid && cmd.ready) begin
				if (cmd.func == FUNC_LOAD) begin
					tune_freq[cmd.load_index] = cmd.load_frequency;
					tune_dur[cmd.load_index]  = cmd.load_duration;
				end else if (countdown != '0) begin
					countdown = countdown - 1'b1;
				end else begin
					due = start_note();
					if (!due.on)
						silent_notes++;
					else if (due.rate == '0)
						clipped_notes++;
					notes_due.push_back(due);
				end
			end
			pending <= notes_due.size();
		end
	end

endmodule

// ----- tb/sv/tone_melody_sequencer_top_test.sv -----
// Sequencer testbench top: clock, reset, command and note traffic, watchdog and verdict.
`timescale 1ns / 100ps

module tone_melody_sequencer_top_test;
	import tmsq_pkg::*;

	localparam int ITEM_TARGET = 1850;
	localparam int HOLD_AT     = 700;
	localparam int HOLD_CYCLES = 400;
	localparam int STALL_LIMIT = 3000;
	localparam int TAIL_CYCLES = 40;

	logic clk = 1'b0;
	logic arst_n;

	int words_sent;
	int loads_sent;
	int ticks_sent;
	int send_calm_left;
	bit send_calm;

	int fails;
	int pending;
	int notes_checked;
	int silent_notes;
	int clipped_notes;

	tmsq_cmd_if  cmd_ch ();
	tmsq_note_if note_ch ();

	tone_melody_sequencer_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.note   (note_ch)
	);

	tone_melody_sequencer_check note_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd_ch),
		.note          (note_ch),
		.fails         (fails),
		.pending       (pending),
		.notes_checked (notes_checked),
		.silent_notes  (silent_notes),
		.clipped_notes (clipped_notes)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// mostly short gaps, now and then a long one
	function automatic int idle_len();
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(10, 60);
		return $urandom_range(1, 3);
	endfunction

	function automatic logic [FREQ_W-1:0] pick_freq();
		case ($urandom_range(0, 9))
			0: return FREQ_W'($urandom_range(1, 63));
			1: return FREQ_W'($urandom_range(64, 65));
			2: return '1;
			3: return FREQ_W'($urandom_range(66, 200));
			default: return FREQ_W'($urandom_range(1, 4095));
		endcase
	endfunction

	// short notes keep the countdown from swallowing the run
	function automatic logic [DUR_W-1:0] pick_dur();
		int r;
		r = $urandom_range(0, 19);
		if (r < 14)
			return DUR_W'($urandom_range(0, 2));
		if (r < 19)
			return DUR_W'($urandom_range(3, 12));
		return DUR_W'($urandom_range(13, 60));
	endfunction

	task automatic push_word(input logic func, input logic [IDX_W-1:0] idx,
		input logic [FREQ_W-1:0] freq, input logic [DUR_W-1:0] dur);
		if (send_calm_left == 0) begin
			send_calm = ($urandom_range(0, 3) == 0);
			send_calm_left = $urandom_range(20, 120);
		end
		send_calm_left--;
		if (!send_calm && $urandom_range(0, 2) == 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (idle_len()) @(posedge clk);
		end
		cmd_ch.valid          <= 1'b1;
		cmd_ch.func           <= func;
		cmd_ch.load_index     <= idx;
		cmd_ch.load_frequency <= freq;
		cmd_ch.load_duration  <= dur;
		do @(posedge clk); while (!cmd_ch.ready);
		words_sent++;
		if (func == FUNC_LOAD)
			loads_sent++;
		else
			ticks_sent++;
	endtask

	task automatic send_load(input logic [IDX_W-1:0] idx, input logic [FREQ_W-1:0] freq,
		input logic [DUR_W-1:0] dur);
		push_word(FUNC_LOAD, idx, freq, dur);
	endtask

	// load fields of a tick are don't-care, so scramble them
	task automatic send_tick();
		push_word(FUNC_TICK, IDX_W'($urandom), FREQ_W'($urandom), DUR_W'($urandom));
	endtask

	task automatic send_noise_load();
		send_load(IDX_W'($urandom_range(0, TBL_DEPTH - 1)),
			($urandom_range(0, 3) == 0) ? '0 : pick_freq(), pick_dur());
	endtask

	initial begin : stimulus
		int span;
		int len;
		int n;
		logic [DUR_W-1:0] dur;

		words_sent = 0;
		loads_sent = 0;
		ticks_sent = 0;
		send_calm_left = 0;
		send_calm = 1'b0;
		arst_n                <= 1'b0;
		cmd_ch.valid          <= 1'b0;
		cmd_ch.func           <= FUNC_TICK;
		cmd_ch.load_index     <= '0;
		cmd_ch.load_frequency <= '0;
		cmd_ch.load_duration  <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		send_tick();                          // empty table: silent word at 0
		send_load(5'd0, 12'd4095, 16'd0);
		send_load(5'd1, 12'd1, 16'd1);        // rate clips at zero
		send_load(5'd2, 12'd63, 16'd0);
		send_load(5'd3, 12'd64, 16'd0);       // exactly zero rate
		send_load(5'd4, 12'd65, 16'd2);
		send_load(5'd5, 12'd0, 16'd0);        // end of melody
		send_load(5'd31, 12'hFFF, 16'hFFFF);
		send_load(5'd31, 12'h800, 16'h0000);
		repeat (9) send_tick();               // through the melody and back to 0
		send_load(5'd1, 12'd0, 16'd1);        // silent note mid-melody
		send_tick();
		send_tick();

		while (words_sent < ITEM_TARGET) begin
			if ($urandom_range(0, 4) != 0) begin
				case ($urandom_range(0, 9))
					0, 1: len = TBL_DEPTH;
					2, 3, 4: len = $urandom_range(7, TBL_DEPTH - 1);
					default: len = $urandom_range(1, 6);
				endcase
				span = 0;
				for (int i = 0; i < len; i++) begin
					dur = pick_dur();
					send_load(IDX_W'(i), pick_freq(), dur);
					span += int'(dur) + 1;
				end
				if (len < TBL_DEPTH)
					send_load(IDX_W'(len), '0, pick_dur());
				n = $urandom_range(span / 2 + 1, span + len + 4);
				repeat (n) begin
					if ($urandom_range(0, 11) == 0)
						send_noise_load();
					send_tick();
				end
			end else begin
				repeat ($urandom_range(1, 6)) begin
					if ($urandom_range(0, 1) == 0)
						send_tick();
					else
						send_noise_load();
				end
			end
		end

		cmd_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		@(negedge clk);
		$display("covered %0d command words: %0d table loads, %0d ticks",
			words_sent, loads_sent, ticks_sent);
		$display("checked %0d note words: %0d silent, %0d with the rate clipped at zero",
			notes_checked, silent_notes, clipped_notes);
		if (pending != 0)
			$display("%0d note words never arrived", pending);
		if (fails == 0 && pending == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// note side: random stalls, calm stretches, and one long hold-off to back the block up
	initial begin : note_sink
		int stall_left;
		int phase_left;
		bit calm;
		bit hold_done;

		stall_left = 0;
		phase_left = 0;
		calm = 1'b0;
		hold_done = 1'b0;
		note_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (phase_left == 0) begin
				calm = ($urandom_range(0, 3) == 0);
				phase_left = $urandom_range(50, 300);
			end
			phase_left--;
			if (!hold_done && words_sent >= HOLD_AT) begin
				hold_done = 1'b1;
				stall_left = HOLD_CYCLES;
			end
			if (stall_left > 0) begin
				stall_left--;
				note_ch.ready <= 1'b0;
			end else if (calm || $urandom_range(0, 3) != 0) begin
				note_ch.ready <= 1'b1;
			end else begin
				stall_left = idle_len() - 1;
				note_ch.ready <= 1'b0;
			end
		end
	end

	initial begin : watchdog
		int quiet;

		quiet = 0;
		@(posedge arst_n);
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((cmd_ch.valid && cmd_ch.ready) || (note_ch.valid && note_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("no word moved for %0d cycles", STALL_LIMIT);
		$display("simulation failed");
		$finish;
	end

endmodule
